// ===== design/pmd_pkg.sv =====
// Shared types and constants for the PS/2 mouse packet decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package pmd_pkg;

	localparam int EV_COUNT = 5;
	localparam int EV_X = 0;
	localparam int EV_Y = 1;
	localparam int EV_LEFT = 2;
	localparam int EV_RIGHT = 3;
	localparam int EV_MIDDLE = 4;

	localparam int SYNC_BIT = 3;

	localparam logic KIND_MOVE = 1'b0;
	localparam logic KIND_BUTTON = 1'b1;

	localparam logic [1:0] CODE_X = 2'd0;
	localparam logic [1:0] CODE_Y = 2'd1;
	localparam logic [1:0] CODE_LEFT = 2'd0;
	localparam logic [1:0] CODE_RIGHT = 2'd1;
	localparam logic [1:0] CODE_MIDDLE = 2'd2;

	typedef enum logic [1:0] {
		POS_FIRST = 2'd0,
		POS_SECOND = 2'd1,
		POS_THIRD = 2'd2
	} pos_t;

	typedef struct packed {
		logic [7:0] dx;
		logic [8:0] dy;
		logic [2:0] buttons;
		logic [EV_COUNT-1:0] mask;
	} pkt_t;

endpackage

// ===== design/pmd_front.sv =====
// Front part: accepts mouse bytes, resyncs, assembles packets and classifies events.
// Pushes one packet record per packet with at least one event. Depends on pmd_pkg.
module pmd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic           cfg_wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     data_byte,
	input  logic           q_full,
	output logic           push,
	output pmd_pkg::pkt_t  push_rec
);

	logic enable_q;
	pmd_pkg::pos_t pos_q;
	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [2:0] prev_buttons_q;
	logic accept;
	logic completes;
	logic [2:0] changed;

	assign in_stall = q_full;
	assign accept = in_valid && !in_stall && enable_q;
	assign completes = accept && (pos_q == pmd_pkg::POS_THIRD);
	assign changed = held0_q[2:0] ^ prev_buttons_q;

	always_comb begin
		push_rec.dx = held1_q;
		push_rec.dy = 9'd0 - {data_byte[7], data_byte};
		push_rec.buttons = held0_q[2:0];
		push_rec.mask[pmd_pkg::EV_X] = (held1_q != 8'd0);
		push_rec.mask[pmd_pkg::EV_Y] = (data_byte != 8'd0);
		push_rec.mask[pmd_pkg::EV_LEFT] = changed[0];
		push_rec.mask[pmd_pkg::EV_RIGHT] = changed[1];
		push_rec.mask[pmd_pkg::EV_MIDDLE] = changed[2];
	end

	assign push = completes && (push_rec.mask != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			pos_q <= pmd_pkg::POS_FIRST;
			prev_buttons_q <= 3'd0;
		end else begin
			if (cfg_wr_en) begin
				enable_q <= cfg_wr_data;
			end
			if (accept) begin
				unique case (pos_q)
					pmd_pkg::POS_FIRST: begin
						if (data_byte[pmd_pkg::SYNC_BIT]) begin
							pos_q <= pmd_pkg::POS_SECOND;
						end
					end
					pmd_pkg::POS_SECOND: begin
						pos_q <= pmd_pkg::POS_THIRD;
					end
					default: begin
						pos_q <= pmd_pkg::POS_FIRST;
						prev_buttons_q <= held0_q[2:0];
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q == pmd_pkg::POS_FIRST) begin
			held0_q <= data_byte;
		end
		if (accept && pos_q == pmd_pkg::POS_SECOND) begin
			held1_q <= data_byte;
		end
	end

endmodule

// ===== design/pmd_queue.sv =====
// Two-entry queue of packet records between the front and back parts.
// Depends on pmd_pkg for the record type.
module pmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pmd_pkg::pkt_t  push_rec,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output pmd_pkg::pkt_t  head_rec
);

	pmd_pkg::pkt_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_rec = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== design/pmd_back.sv =====
// Back part: walks a packet record's pending events, one per cycle when
// not stalled, into the registered output channel. Depends on pmd_pkg.
module pmd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  pmd_pkg::pkt_t       head_rec,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                event_kind,
	output logic [1:0]          event_code,
	output logic signed [8:0]   event_value,
	output logic                last_of_run
);

	pmd_pkg::pkt_t rec_q;
	logic [pmd_pkg::EV_COUNT-1:0] pending_q;
	logic out_valid_q;
	logic kind_q;
	logic [1:0] code_q;
	logic [8:0] value_q;
	logic last_q;

	logic can_load;
	logic emit;
	logic [pmd_pkg::EV_COUNT-1:0] sel;
	logic [pmd_pkg::EV_COUNT-1:0] rest;
	logic nx_kind;
	logic [1:0] nx_code;
	logic [8:0] nx_value;

	assign can_load = !out_valid_q || !out_stall;
	assign emit = can_load && (pending_q != '0);
	assign sel = pending_q & (~pending_q + 1'b1);
	assign rest = pending_q & ~sel;
	assign pop = head_valid && (emit ? (rest == '0) : (pending_q == '0));

	always_comb begin
		nx_kind = pmd_pkg::KIND_BUTTON;
		nx_code = pmd_pkg::CODE_MIDDLE;
		nx_value = {8'd0, rec_q.buttons[2]};
		priority if (sel[pmd_pkg::EV_X]) begin
			nx_kind = pmd_pkg::KIND_MOVE;
			nx_code = pmd_pkg::CODE_X;
			nx_value = {rec_q.dx[7], rec_q.dx};
		end else if (sel[pmd_pkg::EV_Y]) begin
			nx_kind = pmd_pkg::KIND_MOVE;
			nx_code = pmd_pkg::CODE_Y;
			nx_value = rec_q.dy;
		end else if (sel[pmd_pkg::EV_LEFT]) begin
			nx_code = pmd_pkg::CODE_LEFT;
			nx_value = {8'd0, rec_q.buttons[0]};
		end else if (sel[pmd_pkg::EV_RIGHT]) begin
			nx_code = pmd_pkg::CODE_RIGHT;
			nx_value = {8'd0, rec_q.buttons[1]};
		end else begin
			nx_code = pmd_pkg::CODE_MIDDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				pending_q <= head_rec.mask;
			end else if (emit) begin
				pending_q <= rest;
			end
			if (can_load) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rec_q <= head_rec;
		end
		if (emit) begin
			kind_q <= nx_kind;
			code_q <= nx_code;
			value_q <= nx_value;
			last_q <= (rest == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign event_kind = kind_q;
	assign event_code = code_q;
	assign event_value = $signed(value_q);
	assign last_of_run = last_q;

	a_move_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == pmd_pkg::KIND_MOVE |-> value_q != 9'd0)
		else $error("move event with zero displacement");

	a_button_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == pmd_pkg::KIND_BUTTON |-> value_q[8:1] == 8'd0)
		else $error("button event value is not 0 or 1");

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_stall && !last_q |=> out_valid_q)
		else $error("event run broken before its last event");

endmodule

// ===== design/ps2_mouse_packet_decoder_core.sv =====
// Top level of the PS/2 mouse packet decoder: front, queue and back parts.
// Depends on pmd_pkg, pmd_front, pmd_queue and pmd_back.
//
//   channel | handshake            | payload
//   --------+----------------------+----------------------------------------------
//   in      | in_valid / in_stall  | data_byte
//   out     | out_valid / out_stall| event_kind, event_code, event_value, last_of_run
//   cfg     | cfg_wr_en            | cfg_wr_data (enable)
//
// A byte is accepted every cycle while the two-entry packet queue has room.
// A completing byte yields up to five events, sent one per cycle from the
// back part while the output is not stalled.
// Reset clears the byte position and button history and sets enable.
// An output stall holds the event register; the queue absorbs two packets
// before the input stalls.
module ps2_mouse_packet_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               event_kind,
	output logic [1:0]         event_code,
	output logic signed [8:0]  event_value,
	output logic               last_of_run
);

	logic q_full;
	logic push;
	pmd_pkg::pkt_t push_rec;
	logic pop;
	logic head_valid;
	pmd_pkg::pkt_t head_rec;

	pmd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_byte   (data_byte),
		.q_full      (q_full),
		.push        (push),
		.push_rec    (push_rec)
	);

	pmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	pmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_rec    (head_rec),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.event_code  (event_code),
		.event_value (event_value),
		.last_of_run (last_of_run)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for ps2_mouse_packet_decoder_core: directed and random mouse bytes,
// with a local packet decoder predicting the event stream and a monitor checking it in order.
// Depends on pmd_pkg and the ps2_mouse_packet_decoder_core RTL.
module testbench;

	localparam int SETTLE_CYCLES = 20;
	localparam int CYCLE_LIMIT = 200000;
	localparam int BACKLOG_CYCLES = 300;

	typedef struct packed {
		logic              kind;
		logic [1:0]        code;
		logic signed [8:0] value;
		logic              last_flag;
	} mouse_event_t;

	localparam logic [1:0] BUTTON_CODE [3] = '{pmd_pkg::CODE_LEFT, pmd_pkg::CODE_RIGHT,
		pmd_pkg::CODE_MIDDLE};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_wr_data = 1'b0;
	logic in_valid = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	logic event_kind;
	logic [1:0] event_code;
	logic signed [8:0] event_value;
	logic last_of_run;

	logic model_enable = 1'b1;
	pmd_pkg::pos_t model_pos = pmd_pkg::POS_FIRST;
	logic [7:0] model_held [2];
	logic [2:0] model_buttons = 3'b000;

	logic [7:0] pending_bytes[$];
	mouse_event_t expected_events[$];
	mouse_event_t want;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_send = 1'b0;
	logic hold_recv = 1'b0;
	int error_count = 0;
	int cycle_count = 0;

	ps2_mouse_packet_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.event_kind(event_kind),
		.event_code(event_code),
		.event_value(event_value),
		.last_of_run(last_of_run)
	);

	always #2 clk = ~clk;

	function automatic void decode_mouse_byte(input logic [7:0] b);
		logic signed [8:0] dx;
		logic signed [8:0] dy;
		logic [2:0] buttons;
		logic [2:0] changed;
		mouse_event_t run_events [5];
		int n;
		n = 0;
		if (!model_enable)
			return;
		if (model_pos == pmd_pkg::POS_FIRST && !b[pmd_pkg::SYNC_BIT])
			return;
		if (model_pos != pmd_pkg::POS_THIRD) begin
			model_held[model_pos[0]] = b;
			model_pos = pmd_pkg::pos_t'(model_pos + 2'd1);
			return;
		end
		model_pos = pmd_pkg::POS_FIRST;
		dx = $signed({model_held[1][7], model_held[1]});
		dy = -$signed({b[7], b});
		if (dx != 0) begin
			run_events[n] = '{pmd_pkg::KIND_MOVE, pmd_pkg::CODE_X, dx, 1'b0};
			n++;
		end
		if (dy != 0) begin
			run_events[n] = '{pmd_pkg::KIND_MOVE, pmd_pkg::CODE_Y, dy, 1'b0};
			n++;
		end
		buttons = model_held[0][2:0];
		changed = buttons ^ model_buttons;
		for (int i = 0; i < 3; i++) begin
			if (changed[i]) begin
				run_events[n] = '{pmd_pkg::KIND_BUTTON, BUTTON_CODE[i], {8'd0, buttons[i]},
					1'b0};
				n++;
			end
		end
		model_buttons = buttons;
		if (n > 0)
			run_events[n-1].last_flag = 1'b1;
		for (int i = 0; i < n; i++)
			expected_events.push_back(run_events[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			data_byte <= 8'h00;
		end else begin
			if (in_valid && !in_stall)
				decode_mouse_byte(data_byte);
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && !hold_send
						&& $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					data_byte <= pending_bytes.pop_front();
				end else begin
					in_valid <= 1'b0;
					data_byte <= 8'($urandom);
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event kind %0b code %0d value %0d",
						event_kind, event_code, event_value));
				end else begin
					want = expected_events.pop_front();
					if (event_kind !== want.kind)
						report_mismatch($sformatf("event_kind %0b, want %0b", event_kind, want.kind));
					if (event_code !== want.code)
						report_mismatch($sformatf("event_code %0d, want %0d", event_code, want.code));
					if (event_value !== want.value)
						report_mismatch($sformatf("event_value %0d, want %0d",
							event_value, want.value));
					if (last_of_run !== want.last_flag)
						report_mismatch($sformatf("last_of_run %0b, want %0b",
							last_of_run, want.last_flag));
				end
			end
			out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
		end
	end

	task automatic write_enable(input logic value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		model_enable = value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		@(negedge clk);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic push_packet(input logic [7:0] status, input logic [7:0] dx,
			input logic [7:0] dy);
		pending_bytes.push_back(status);
		pending_bytes.push_back(dx);
		pending_bytes.push_back(dy);
	endtask

	function automatic logic [7:0] random_motion();
		return ($urandom_range(4) == 0) ? 8'h00 : 8'($urandom);
	endfunction

	task automatic add_random_bytes(input int count);
		logic [7:0] status;
		int added;
		added = 0;
		while (added < count) begin
			if ($urandom_range(99) < 85) begin
				status = 8'($urandom);
				status[pmd_pkg::SYNC_BIT] = 1'b1;
				push_packet(status, random_motion(), random_motion());
				added += 3;
			end else begin
				pending_bytes.push_back(8'($urandom));
				added++;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		write_enable(1'b1);

		set_idling(0, 0);
		pending_bytes.push_back(8'h00);
		push_packet(8'h0F, 8'h7F, 8'h80);
		push_packet(8'hF8, 8'h80, 8'h7F);
		push_packet(8'h08, 8'h00, 8'h00);
		push_packet(8'h09, 8'h01, 8'h00);
		push_packet(8'h0A, 8'h00, 8'hFF);
		wait_drained();

		set_idling(67, 0);
		add_random_bytes(20);
		wait_drained();

		// Halfway through, the sender holds its next request until every event is out.
		set_idling(0, 67);
		add_random_bytes(24);
		do
			@(negedge clk);
		while (pending_bytes.size() > 12);
		hold_send = 1'b1;
		do
			@(negedge clk);
		while (in_valid || expected_events.size() != 0);
		hold_send = 1'b0;
		wait_drained();

		write_enable(1'b0);
		set_idling(30, 30);
		add_random_bytes(12);
		wait_drained();

		write_enable(1'b1);
		add_random_bytes(20);
		wait_drained();

		// A long output hold-off lets the packet queue fill and back up the input.
		set_idling(0, 0);
		fork
			begin
				hold_recv = 1'b1;
				repeat (BACKLOG_CYCLES) @(negedge clk);
				hold_recv = 1'b0;
			end
		join_none
		add_random_bytes(30);
		wait_drained();

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
